### rtl/core/mvn_pkg.sv
// shared types and constants for the motion vector l2 normalizer
`timescale 1ns / 1ps
`default_nettype none
package mvn_pkg;

  localparam int unsigned LANES    = 5;
  localparam int unsigned COMP_W   = 16;
  localparam int unsigned SQ_W     = 31;
  localparam int unsigned SUM_W    = 33;
  localparam int unsigned QUO_W    = 31;
  localparam int unsigned ROOT_W   = 15;
  localparam int unsigned SUM_LAT  = 2;
  localparam int unsigned LANE_LAT = 49;
  localparam int unsigned PIPE_LAT = SUM_LAT + LANE_LAT;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic [SQ_W-1:0]          sq_t;
  typedef logic [SUM_W-1:0]         sum_t;

  typedef struct packed {
    comp_t [LANES-1:0] norm;
    logic              zero;
    logic              last;
  } res_t;

endpackage
`default_nettype wire

### rtl/core/motion_vector_l2_normalize.sv
// motion vector l2 normalizer top level
// each input word carries five signed q8.8 components and a last-group mark;
// each output word carries the five components scaled to unit length in
// signed q1.14, a zero_length flag (all-zero input, outputs zero) and the mark.
// both channels use valid/stall; a word moves when valid is high and stall low.
// one word is taken per cycle while stall_o is low; there is no dependence between words.
// a word passes the squares and sum, then the five lanes (input register,
// 31 divide steps, root load, 15 square-root steps, rounding), then
// the two-entry output buffer.
// when stall_i holds, results collect in the output buffer; once it is full
// the whole pipeline freezes and stall_o rises until a word leaves.
// reset clears the pipeline valid bits and empties the output buffer; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module motion_vector_l2_normalize (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output      logic                  stall_o,
  input  wire mvn_pkg::comp_t        comp_0_i,
  input  wire mvn_pkg::comp_t        comp_1_i,
  input  wire mvn_pkg::comp_t        comp_2_i,
  input  wire mvn_pkg::comp_t        comp_3_i,
  input  wire mvn_pkg::comp_t        comp_4_i,
  input  wire logic                  last_group_i,
  output      logic                  valid_o,
  input  wire logic                  stall_i,
  output      mvn_pkg::comp_t        norm_0_o,
  output      mvn_pkg::comp_t        norm_1_o,
  output      mvn_pkg::comp_t        norm_2_o,
  output      mvn_pkg::comp_t        norm_3_o,
  output      mvn_pkg::comp_t        norm_4_o,
  output      logic                  zero_length_o,
  output      logic                  last_out_o
);
  import mvn_pkg::*;

  logic               en;
  comp_t [LANES-1:0]  comp;
  sq_t   [LANES-1:0]  sq;
  logic  [LANES-1:0]  neg;
  sum_t               sum;
  comp_t [LANES-1:0]  norm;

  logic [PIPE_LAT-1:0] vld_q, last_q;
  logic [LANE_LAT-1:0] zero_q;

  res_t       buf_q [0:1];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  res_t       res;

  assign comp = {comp_4_i, comp_3_i, comp_2_i, comp_1_i, comp_0_i};
  assign en   = (cnt_q != 2'd2);

  mvn_sumsq u_sumsq (
    .clk_i  (clk_i),
    .en_i   (en),
    .comp_i (comp),
    .sq_o   (sq),
    .neg_o  (neg),
    .sum_o  (sum)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    mvn_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .sq_i   (sq[i]),
      .sum_i  (sum),
      .neg_i  (neg[i]),
      .norm_o (norm[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      last_q <= {last_q[PIPE_LAT-2:0], last_group_i};
      zero_q <= {zero_q[LANE_LAT-2:0], (sum == '0)};
    end
  end

  always_comb begin
    res.zero = zero_q[LANE_LAT-1];
    res.last = last_q[PIPE_LAT-1];
    for (int i = 0; i < LANES; i++) begin
      res.norm[i] = res.zero ? '0 : norm[i];
    end
  end

  assign push = en && vld_q[PIPE_LAT-1];
  assign pop  = valid_o && !stall_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wptr_q <= !wptr_q;
      end
      if (pop) begin
        rptr_q <= !rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= res;
    end
  end

  assign stall_o       = !en;
  assign valid_o       = (cnt_q != 2'd0);
  assign norm_0_o      = buf_q[rptr_q].norm[0];
  assign norm_1_o      = buf_q[rptr_q].norm[1];
  assign norm_2_o      = buf_q[rptr_q].norm[2];
  assign norm_3_o      = buf_q[rptr_q].norm[3];
  assign norm_4_o      = buf_q[rptr_q].norm[4];
  assign zero_length_o = buf_q[rptr_q].zero;
  assign last_out_o    = buf_q[rptr_q].last;
endmodule
`default_nettype wire

### rtl/core/mvn_sumsq.sv
// squares of the components and their sum
`timescale 1ns / 1ps
`default_nettype none
module mvn_sumsq (
  input  wire logic                                     clk_i,
  input  wire logic                                     en_i,
  input  wire mvn_pkg::comp_t [mvn_pkg::LANES-1:0]      comp_i,
  output      mvn_pkg::sq_t   [mvn_pkg::LANES-1:0]      sq_o,
  output      logic           [mvn_pkg::LANES-1:0]      neg_o,
  output      mvn_pkg::sum_t                            sum_o
);
  import mvn_pkg::*;

  sq_t  [LANES-1:0] sq1_q, sq2_q;
  logic [LANES-1:0] neg1_q, neg2_q;
  sum_t             sum_q;
  sum_t             sum_d;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < LANES; i++) begin
      sum_d = sum_d + SUM_W'(sq1_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < LANES; i++) begin
        sq1_q[i]  <= SQ_W'($signed(comp_i[i]) * $signed(comp_i[i]));
        neg1_q[i] <= comp_i[i][COMP_W-1];
      end
      sq2_q  <= sq1_q;
      neg2_q <= neg1_q;
      sum_q  <= sum_d;
    end
  end

  assign sq_o  = sq2_q;
  assign neg_o = neg2_q;
  assign sum_o = sum_q;
endmodule
`default_nettype wire

### rtl/core/mvn_lane.sv
// one lane: pipelined divide, square root and rounding
`timescale 1ns / 1ps
`default_nettype none
module mvn_lane (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire mvn_pkg::sq_t   sq_i,
  input  wire mvn_pkg::sum_t  sum_i,
  input  wire logic           neg_i,
  output      mvn_pkg::comp_t norm_o
);
  import mvn_pkg::*;

  localparam int unsigned NDIV = QUO_W;
  localparam int unsigned NSQ  = ROOT_W;
  localparam int unsigned RW   = QUO_W - 2;

  logic [SUM_W-1:0]  drem_q [0:NDIV];
  sum_t              ds_q   [0:NDIV];
  logic [QUO_W-1:0]  dq_q   [0:NDIV];
  logic              dn_q   [0:NDIV];

  logic [RW:0]       sr_q   [0:NSQ];
  logic [ROOT_W-1:0] sm_q   [0:NSQ];
  logic [1:0]        sl_q   [0:NSQ];
  logic              sn_q   [0:NSQ];

  comp_t             norm_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      drem_q[0] <= SUM_W'(sq_i);
      ds_q[0]   <= sum_i;
      dq_q[0]   <= '0;
      dn_q[0]   <= neg_i;
    end
  end

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    logic [SUM_W:0] sh;
    logic [SUM_W:0] diff;
    logic           take;
    always_comb begin
      sh   = (k == 0) ? {1'b0, drem_q[k]} : {drem_q[k], 1'b0};
      diff = sh - {1'b0, ds_q[k]};
      take = (sh >= {1'b0, ds_q[k]});
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        drem_q[k+1] <= take ? diff[SUM_W-1:0] : sh[SUM_W-1:0];
        ds_q[k+1]   <= ds_q[k];
        dq_q[k+1]   <= {dq_q[k][QUO_W-2:0], take};
        dn_q[k+1]   <= dn_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= {1'b0, dq_q[NDIV][QUO_W-1:2]};
      sm_q[0] <= '0;
      sl_q[0] <= dq_q[NDIV][1:0];
      sn_q[0] <= dn_q[NDIV];
    end
  end

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    localparam int unsigned B = NSQ - 1 - j;
    logic [RW+1:0] need;
    logic          take;
    always_comb begin
      need = ((RW+2)'(sm_q[j]) << (B + 1)) + ((RW+2)'(1) << (2 * B));
      take = ({1'b0, sr_q[j]} >= need);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sr_q[j+1] <= take ? (RW+1)'({1'b0, sr_q[j]} - need) : sr_q[j];
        sm_q[j+1] <= take ? (sm_q[j] | (ROOT_W'(1) << B)) : sm_q[j];
        sl_q[j+1] <= sl_q[j];
        sn_q[j+1] <= sn_q[j];
      end
    end
  end

  logic [RW+3:0]   lhs, rhs;
  logic [COMP_W-1:0] mag;

  always_comb begin
    lhs = (RW+4)'({sr_q[NSQ], 2'b00}) + (RW+4)'(sl_q[NSQ]);
    rhs = ((RW+4)'(sm_q[NSQ]) << 2) + (RW+4)'(1);
    mag = COMP_W'(sm_q[NSQ]) + COMP_W'(lhs >= rhs);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      norm_q <= sn_q[NSQ] ? -mag : mag;
    end
  end

  assign norm_o = norm_q;
endmodule
`default_nettype wire
